FILE: src/shift_reduce_expr_parser_assert.svh
// Assertion macros used by the checker file of the expression parser.
`ifndef SHIFT_REDUCE_EXPR_PARSER_ASSERT_SVH
`define SHIFT_REDUCE_EXPR_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/srp_pkg.sv
// Types, codes and constants of the shift-reduce expression parser.
`default_nettype none

package srp_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned LevelW        = 7;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } srp_in_t;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [1:0]        reductions_done;
    logic [LevelW-1:0] stack_level;
  } srp_out_t;

  localparam logic [2:0] VerdictPending  = 3'd0;
  localparam logic [2:0] VerdictAccept   = 3'd1;
  localparam logic [2:0] VerdictSyntax   = 3'd2;
  localparam logic [2:0] VerdictBadChar  = 3'd3;
  localparam logic [2:0] VerdictOverflow = 3'd4;

  typedef enum logic [2:0] {
    SYM_ID   = 3'd0,
    SYM_E    = 3'd1,
    SYM_PLUS = 3'd2,
    SYM_STAR = 3'd3,
    SYM_LPAR = 3'd4,
    SYM_RPAR = 3'd5
  } sym_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BADCHAR  = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CH_SPACE = 2'd0,
    CH_TOKEN = 2'd1,
    CH_I     = 2'd2,
    CH_BAD   = 2'd3
  } ch_class_e;

  typedef enum logic [1:0] {
    RULE_NONE  = 2'd0,
    RULE_ID    = 2'd1,
    RULE_PAREN = 2'd2,
    RULE_BIN   = 2'd3
  } rule_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_REDUCE = 3'd2,
    ST_FILL   = 3'd3,
    ST_FINISH = 3'd4
  } state_e;

  typedef struct packed {
    logic      end_item;
    logic      err_held;
    logic      pend_i;
    logic      is_d;
    logic      full;
    logic      red_max;
    ch_class_e ch_class;
    rule_e     rule;
  } srp_status_t;

  typedef struct packed {
    logic load_item;
    logic push;
    logic set_pend;
    logic clr_pend;
    logic set_bad;
    logic set_ovf;
    logic reduce;
    logic fill;
    logic load_out;
    logic clear_all;
  } srp_cmd_t;

endpackage

`default_nettype wire

FILE: src/srp_ctrl.sv
// Sequencer of the expression parser: item intake, reduction loop, result handoff.
`default_nettype none

module srp_ctrl
  import srp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire srp_status_t status_i,
  output srp_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FINISH;
        if (status_i.end_item) begin
          if (!status_i.err_held && !status_i.pend_i) begin
            state_d = ST_REDUCE;
          end
        end else if (status_i.err_held) begin
          state_d = ST_FINISH;
        end else if (status_i.pend_i) begin
          cmd_o.clr_pend = 1'b1;
          if (!status_i.is_d) begin
            cmd_o.set_bad = 1'b1;
          end else if (status_i.full) begin
            cmd_o.set_ovf = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
            state_d    = ST_REDUCE;
          end
        end else begin
          case (status_i.ch_class)
            CH_SPACE: state_d = ST_FINISH;
            CH_TOKEN: begin
              if (status_i.full) begin
                cmd_o.set_ovf = 1'b1;
              end else begin
                cmd_o.push = 1'b1;
                state_d    = ST_REDUCE;
              end
            end
            CH_I:     cmd_o.set_pend = 1'b1;
            default:  cmd_o.set_bad = 1'b1;
          endcase
        end
      end
      ST_REDUCE: begin
        if (status_i.red_max || status_i.rule == RULE_NONE) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.reduce = 1'b1;
          state_d      = (status_i.rule == RULE_ID) ? ST_REDUCE : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_REDUCE;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.clear_all = status_i.end_item;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/srp_dpath.sv
// Datapath of the expression parser: symbol stack, top-of-stack window, result register.
`default_nettype none

module srp_dpath
  import srp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire srp_in_t  in_data_i,
  input  wire srp_cmd_t cmd_i,
  output srp_status_t   status_o,
  output srp_out_t      out_data_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChD     = 8'h64;

  logic [7:0]    ch_q;
  logic          end_q;
  logic [CW-1:0] count_q;
  logic          pend_q;
  logic          seen_q;
  err_e          err_q;
  logic [1:0]    reds_q;
  sym_e          win0_q, win1_q, win2_q;
  sym_e          rd_a_q, rd_b_q;
  srp_out_t      out_q;
  sym_e          mem_q [STACK_DEPTH];

  ch_class_e ch_class;
  sym_e      ch_sym, push_sym;
  rule_e     rule;
  err_e      err_eff;
  logic      accept_ok;

  logic [CW-1:0] idx_m1, idx_m3, idx_m4, idx_m5;
  logic [LevelW+CW-1:0] level_wide;
  srp_out_t out_d;

  // Character decode.
  always_comb begin
    ch_sym   = SYM_PLUS;
    ch_class = CH_TOKEN;
    case (ch_q)
      ChSpace: ch_class = CH_SPACE;
      ChPlus:  ch_sym   = SYM_PLUS;
      ChStar:  ch_sym   = SYM_STAR;
      ChLpar:  ch_sym   = SYM_LPAR;
      ChRpar:  ch_sym   = SYM_RPAR;
      ChI:     ch_class = CH_I;
      default: ch_class = CH_BAD;
    endcase
  end

  assign push_sym = pend_q ? SYM_ID : ch_sym;

  // Rule match at the stack top, first fit wins.
  always_comb begin
    rule = RULE_NONE;
    if (count_q != '0 && win0_q == SYM_ID) begin
      rule = RULE_ID;
    end else if (count_q >= CW'(3)) begin
      if (win0_q == SYM_RPAR && win1_q == SYM_E && win2_q == SYM_LPAR) begin
        rule = RULE_PAREN;
      end else if (win0_q == SYM_E && win2_q == SYM_E &&
                   (win1_q == SYM_PLUS || win1_q == SYM_STAR)) begin
        rule = RULE_BIN;
      end
    end
  end

  assign idx_m1 = count_q - CW'(1);
  assign idx_m3 = count_q - CW'(3);
  assign idx_m4 = count_q - CW'(4);
  assign idx_m5 = count_q - CW'(5);

  always_comb begin
    status_o          = '0;
    status_o.end_item = end_q;
    status_o.err_held = (err_q != ERR_NONE);
    status_o.pend_i   = pend_q;
    status_o.is_d     = (ch_q == ChD);
    status_o.full     = (count_q == DepthC);
    status_o.red_max  = (reds_q == 2'd3);
    status_o.ch_class = ch_class;
    status_o.rule     = rule;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      seen_q  <= 1'b0;
      err_q   <= ERR_NONE;
      reds_q  <= '0;
    end else begin
      if (cmd_i.load_item) begin
        reds_q <= '0;
      end else if (cmd_i.reduce) begin
        reds_q <= reds_q + 2'd1;
      end
      if (cmd_i.clear_all) begin
        count_q <= '0;
        pend_q  <= 1'b0;
        seen_q  <= 1'b0;
        err_q   <= ERR_NONE;
      end else begin
        if (cmd_i.set_pend) begin
          pend_q <= 1'b1;
        end else if (cmd_i.clr_pend) begin
          pend_q <= 1'b0;
        end
        if (cmd_i.set_bad) begin
          err_q <= ERR_BADCHAR;
        end else if (cmd_i.set_ovf) begin
          err_q <= ERR_OVERFLOW;
        end
        if (cmd_i.push) begin
          count_q <= count_q + CW'(1);
          seen_q  <= 1'b1;
        end else if (cmd_i.reduce && rule != RULE_ID) begin
          count_q <= count_q - CW'(2);
        end
      end
    end
  end

  // Item latch, top-of-stack window, stack memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      ch_q  <= in_data_i.char_byte;
      end_q <= in_data_i.end_of_input;
    end
    if (cmd_i.push) begin
      mem_q[count_q[AW-1:0]] <= push_sym;
      win0_q <= push_sym;
      win1_q <= win0_q;
      win2_q <= win1_q;
    end else if (cmd_i.reduce) begin
      win0_q <= SYM_E;
      if (rule == RULE_ID) begin
        mem_q[idx_m1[AW-1:0]] <= SYM_E;
      end else begin
        mem_q[idx_m3[AW-1:0]] <= SYM_E;
        // Fetch the two symbols that become second and third from the top.
        if (count_q >= CW'(4)) begin
          rd_a_q <= mem_q[idx_m4[AW-1:0]];
        end
        if (count_q >= CW'(5)) begin
          rd_b_q <= mem_q[idx_m5[AW-1:0]];
        end
      end
    end else if (cmd_i.fill) begin
      win1_q <= rd_a_q;
      win2_q <= rd_b_q;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  // Result assembly.
  assign err_eff    = (err_q == ERR_NONE && pend_q) ? ERR_BADCHAR : err_q;
  assign accept_ok  = (count_q == CW'(1)) && (win0_q == SYM_E) && seen_q;
  assign level_wide = {{LevelW{1'b0}}, count_q};

  always_comb begin
    out_d.reductions_done = reds_q;
    out_d.stack_level     = end_q ? '0 : level_wide[LevelW-1:0];
    if (!end_q) begin
      out_d.verdict = VerdictPending;
    end else if (err_eff == ERR_BADCHAR) begin
      out_d.verdict = VerdictBadChar;
    end else if (err_eff == ERR_OVERFLOW) begin
      out_d.verdict = VerdictOverflow;
    end else if (accept_ok) begin
      out_d.verdict = VerdictAccept;
    end else begin
      out_d.verdict = VerdictSyntax;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: src/shift_reduce_expr_parser.sv
// Top level of the shift-reduce expression parser: controller plus datapath.
// Steps: the item is latched and decoded; a skip, lone i or error goes straight to the result,
//   a shift is followed by up to three reductions (id rule: reduce; shrinking rule: reduce, fill).
// Throughput: one item at a time; the next transfer is taken the cycle after the result is
//   loaded into the output register, which then waits for the consumer.
// Reset (rst_ni low, asynchronous): empty stack, no error; stack memory keeps its contents.
`default_nettype none

module shift_reduce_expr_parser
  import srp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // Character channel: one character or an end marker per transfer.
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire srp_in_t  in_data_i,
  // Result channel: one result per input transfer.
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output srp_out_t      out_data_o
);

  srp_cmd_t    cmd;
  srp_status_t status;

  // Sequence each item: decode and shift, reduce greedily, hand off the result.
  srp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the stack, the top-three window and the result register.
  srp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: src/srp_checker.sv
// Port-level checker of the expression parser and its bind to the top level.
`default_nettype none
`include "shift_reduce_expr_parser_assert.svh"

module srp_checker
  import srp_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire srp_out_t out_data_o
);

  // One item in flight: no transfer in right after a transfer in.
  `SRP_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "back-to-back intake")

  // A stalled result holds.
  `SRP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  // A verdict always comes with an emptied stack.
  `SRP_ASSERT_IMP(a_verdict_clears, out_valid_o && out_data_o.verdict != VerdictPending, out_data_o.stack_level == '0, "stack not cleared on verdict")

  // Verdict stays within its defined codes.
  `SRP_ASSERT_IMP(a_verdict_code, out_valid_o, out_data_o.verdict <= VerdictOverflow, "undefined verdict code")

endmodule

bind shift_reduce_expr_parser srp_checker u_srp_checker (.*);

`default_nettype wire
